>>> rtl/core/arfcc_pkg.sv
package arfcc_pkg;

    localparam int CNT_W       = 9;
    localparam int TOT_W       = 32;
    localparam int OP_W        = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [OP_W-1:0] OP_M     = 4'd0;
    localparam logic [OP_W-1:0] OP_I     = 4'd1;
    localparam logic [OP_W-1:0] OP_D     = 4'd2;
    localparam logic [OP_W-1:0] OP_S     = 4'd4;
    localparam logic [OP_W-1:0] OP_LAST  = 4'd8;
    localparam logic [OP_W-1:0] OP_OTHER = 4'd9;
    localparam logic [OP_W-1:0] OP_START = 4'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUALITY_CUTOFF = 1'b0,
        CFG_EXCLUDE_MASK   = 1'b1
    } cfg_reg_e;

    typedef enum logic [1:0] {
        VERDICT_PASS     = 2'd0,
        VERDICT_EXCLUDED = 2'd1,
        VERDICT_LOW_QUAL = 2'd2
    } verdict_e;

    typedef struct packed {
        logic [15:0]     read_flag;
        logic [7:0]      map_quality;
        logic            has_op;
        logic [OP_W-1:0] op_code;
        logic            first_item;
        logic            last_item;
    } in_beat_t;

    typedef struct packed {
        logic             read_pass;
        logic [1:0]       fail_reason;
        logic [CNT_W-1:0] bad_deletions;
        logic [CNT_W-1:0] bad_insertions;
        logic [CNT_W-1:0] fixable_insertions;
        logic             no_match;
        logic [TOT_W-1:0] total_excluded;
        logic [TOT_W-1:0] total_low_quality;
        logic [TOT_W-1:0] total_unaligned;
        logic [TOT_W-1:0] total_bad_deletions;
        logic [TOT_W-1:0] total_bad_insertions;
        logic [TOT_W-1:0] total_fixable_insertions;
    } out_beat_t;

    typedef struct packed {
        logic            first;
        logic            last;
        verdict_e        verdict;
        logic            op_valid;
        logic [OP_W-1:0] op_code;
        logic            excl_inc;
        logic            lowq_inc;
    } op_token_t;

    typedef struct packed {
        logic is_match;
        logic bad_del;
        logic bad_ins;
        logic fix_ins;
    } judge_t;

    function automatic judge_t judge_op(
        input logic [OP_W-1:0] op,
        input logic [OP_W-1:0] prev,
        input logic            has_next,
        input logic [OP_W-1:0] nxt,
        input logic            next_last
    );
        judge_t j;
        logic   framed;
        j      = '0;
        framed = has_next && (nxt == OP_M);
        case (op)
            OP_M: j.is_match = 1'b1;
            OP_D: j.bad_del = (prev != OP_M) || !framed;
            OP_I:
            begin
                if (prev != OP_M)
                begin
                    if (prev != OP_START && prev != OP_S)
                        j.bad_ins = 1'b1;
                    else
                        j.fix_ins = 1'b1;
                end
                else if (!framed)
                begin
                    if (!has_next)
                        j.fix_ins = 1'b1;
                    else if (next_last && nxt == OP_S)
                        j.fix_ins = 1'b1;
                    else
                        j.bad_ins = 1'b1;
                end
            end
            default: ;
        endcase
        return j;
    endfunction

    function automatic logic [CNT_W-1:0] sat_add(
        input logic [CNT_W-1:0] cnt,
        input logic [1:0]       inc
    );
        logic [CNT_W:0] sum;
        sum = {1'b0, cnt} + {{(CNT_W-1){1'b0}}, inc};
        return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    endfunction

endpackage

>>> rtl/core/aligned_read_filter_cigar_check_core.sv
// channel  | handshake            | payload
// ---------+----------------------+------------------------------------
// in       | in_valid / in_ready  | in_data   (in_beat_t), one op a beat
// out      | out_valid/ out_ready | out_data  (out_beat_t), one per read
// cfg      | cfg_valid/ cfg_ready | cfg_index, cfg_data; always ready
//
// One beat a cycle sustained unless out_ready stalls; a result is registered when its
// last beat is popped. The back end sets the rate, judging one queued op per cycle.
// in_ready drops only when the queue is full, i.e. when the result register
// is held by out_ready low, a further last beat waits behind it and one more
// beat is queued after that.
// Async active-low reset clears config, verdict, per-read state and totals.
module aligned_read_filter_cigar_check_core #(
    parameter int QUEUE_DEPTH = arfcc_pkg::QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  arfcc_pkg::in_beat_t              in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output arfcc_pkg::out_beat_t             out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [arfcc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [arfcc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import arfcc_pkg::*;

    op_token_t front_tok;
    op_token_t back_tok;
    logic      q_full;
    logic      q_empty;
    logic      q_pop;
    logic      in_accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign in_accept = in_valid && in_ready;

    arfcc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .beat_accept (in_accept),
        .beat        (in_data),
        .tok         (front_tok)
    );

    arfcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (in_accept),
        .push_tok (front_tok),
        .full     (q_full),
        .pop      (q_pop),
        .pop_tok  (back_tok),
        .empty    (q_empty)
    );

    arfcc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .tok       (back_tok),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> rtl/core/arfcc_front.sv
module arfcc_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [arfcc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [arfcc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             beat_accept,
    input  arfcc_pkg::in_beat_t              beat,
    output arfcc_pkg::op_token_t             tok
);
    import arfcc_pkg::*;

    logic [CNT_W-1:0] quality_cutoff_reg;
    logic [15:0]      exclude_mask_reg;
    verdict_e         verdict_reg;
    verdict_e         verdict_new;
    logic             excl_hit;
    logic             lowq_hit;
    logic [OP_W-1:0]  code_norm;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quality_cutoff_reg <= '0;
            exclude_mask_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_e'(cfg_index))
                CFG_QUALITY_CUTOFF: quality_cutoff_reg <= cfg_data[CNT_W-1:0];
                CFG_EXCLUDE_MASK:   exclude_mask_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        excl_hit  = (beat.read_flag & exclude_mask_reg) != 16'd0;
        lowq_hit  = {1'b0, beat.map_quality} < quality_cutoff_reg;
        code_norm = (beat.op_code > OP_LAST) ? OP_OTHER : beat.op_code;
        if (excl_hit)
            verdict_new = VERDICT_EXCLUDED;
        else if (lowq_hit)
            verdict_new = VERDICT_LOW_QUAL;
        else
            verdict_new = VERDICT_PASS;

        tok.first    = beat.first_item;
        tok.last     = beat.last_item;
        tok.verdict  = beat.first_item ? verdict_new : verdict_reg;
        tok.op_valid = (tok.verdict == VERDICT_PASS) && beat.has_op;
        tok.op_code  = code_norm;
        tok.excl_inc = beat.first_item && excl_hit;
        tok.lowq_inc = beat.first_item && !excl_hit && lowq_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            verdict_reg <= VERDICT_PASS;
        else if (beat_accept && beat.first_item)
            verdict_reg <= verdict_new;
    end

endmodule

>>> rtl/core/arfcc_queue.sv
module arfcc_queue #(
    parameter int DEPTH = arfcc_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  arfcc_pkg::op_token_t push_tok,
    output logic                 full,
    input  logic                 pop,
    output arfcc_pkg::op_token_t pop_tok,
    output logic                 empty
);
    import arfcc_pkg::*;

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    op_token_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full    = count_reg == COUNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign pop_tok = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            case ({push, pop})
                2'b10:   count_reg <= count_reg + COUNT_W'(1);
                2'b01:   count_reg <= count_reg - COUNT_W'(1);
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/core/arfcc_back.sv
module arfcc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 empty,
    input  arfcc_pkg::op_token_t tok,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output arfcc_pkg::out_beat_t out_data
);
    import arfcc_pkg::*;

    logic [OP_W-1:0]  held_op_reg,  held_op_next;
    logic             held_valid_reg, held_valid_next;
    logic [OP_W-1:0]  prior_op_reg, prior_op_next;
    logic             match_seen_reg, match_seen_next;
    logic [CNT_W-1:0] del_cnt_reg, del_cnt_next;
    logic [CNT_W-1:0] ins_cnt_reg, ins_cnt_next;
    logic [CNT_W-1:0] fix_cnt_reg, fix_cnt_next;
    logic [TOT_W-1:0] tot_excl_reg, tot_excl_next;
    logic [TOT_W-1:0] tot_lowq_reg, tot_lowq_next;
    logic [TOT_W-1:0] tot_unal_reg, tot_unal_next;
    logic [TOT_W-1:0] tot_del_reg, tot_del_next;
    logic [TOT_W-1:0] tot_ins_reg, tot_ins_next;
    logic [TOT_W-1:0] tot_fix_reg, tot_fix_next;
    logic             out_valid_reg;
    out_beat_t        out_data_reg, out_data_next;

    logic [OP_W-1:0]  held0, prior0, held1, prior1, prior2;
    logic             hv0, hv1, match0, match1, match2;
    logic [CNT_W-1:0] del0, ins0, fix0;
    logic             use1, use2, passing, nomatch;
    judge_t           j1, j2;
    logic [1:0]       inc_del, inc_ins, inc_fix;

    assign pop       = !empty && (!tok.last || !out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        passing = tok.verdict == VERDICT_PASS;
        hv0     = tok.first ? 1'b0 : held_valid_reg;
        held0   = tok.first ? '0 : held_op_reg;
        prior0  = tok.first ? OP_START : prior_op_reg;
        match0  = tok.first ? 1'b0 : match_seen_reg;
        del0    = tok.first ? '0 : del_cnt_reg;
        ins0    = tok.first ? '0 : ins_cnt_reg;
        fix0    = tok.first ? '0 : fix_cnt_reg;

        // look-ahead judgement of the held op against the incoming one
        use1   = tok.op_valid && hv0;
        j1     = judge_op(held0, prior0, 1'b1, tok.op_code, tok.last);
        prior1 = use1 ? held0 : prior0;
        match1 = match0 | (use1 & j1.is_match);
        held1  = tok.op_valid ? tok.op_code : held0;
        hv1    = tok.op_valid | hv0;

        // end of read: held op has no successor
        use2   = tok.last && passing && hv1;
        j2     = judge_op(held1, prior1, 1'b0, OP_M, 1'b0);
        prior2 = use2 ? held1 : prior1;
        match2 = match1 | (use2 & j2.is_match);

        inc_del = {1'b0, use1 & j1.bad_del} + {1'b0, use2 & j2.bad_del};
        inc_ins = {1'b0, use1 & j1.bad_ins} + {1'b0, use2 & j2.bad_ins};
        inc_fix = {1'b0, use1 & j1.fix_ins} + {1'b0, use2 & j2.fix_ins};
        nomatch = tok.last && passing && (prior2 != OP_START) && !match2;

        del_cnt_next  = sat_add(del0, inc_del);
        ins_cnt_next  = sat_add(ins0, inc_ins);
        fix_cnt_next  = sat_add(fix0, inc_fix);
        tot_excl_next = tot_excl_reg + TOT_W'(tok.excl_inc);
        tot_lowq_next = tot_lowq_reg + TOT_W'(tok.lowq_inc);
        tot_unal_next = tot_unal_reg + TOT_W'(nomatch);
        tot_del_next  = tot_del_reg + TOT_W'(inc_del);
        tot_ins_next  = tot_ins_reg + TOT_W'(inc_ins);
        tot_fix_next  = tot_fix_reg + TOT_W'(inc_fix);

        out_data_next.read_pass                = passing;
        out_data_next.fail_reason              = tok.verdict;
        out_data_next.bad_deletions            = del_cnt_next;
        out_data_next.bad_insertions           = ins_cnt_next;
        out_data_next.fixable_insertions       = fix_cnt_next;
        out_data_next.no_match                 = nomatch;
        out_data_next.total_excluded           = tot_excl_next;
        out_data_next.total_low_quality        = tot_lowq_next;
        out_data_next.total_unaligned          = tot_unal_next;
        out_data_next.total_bad_deletions      = tot_del_next;
        out_data_next.total_bad_insertions     = tot_ins_next;
        out_data_next.total_fixable_insertions = tot_fix_next;

        if (tok.last)
        begin
            held_op_next    = '0;
            held_valid_next = 1'b0;
            prior_op_next   = OP_START;
            match_seen_next = 1'b0;
        end
        else
        begin
            held_op_next    = held1;
            held_valid_next = hv1;
            prior_op_next   = prior2;
            match_seen_next = match2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_op_reg    <= '0;
            held_valid_reg <= 1'b0;
            prior_op_reg   <= OP_START;
            match_seen_reg <= 1'b0;
            del_cnt_reg    <= '0;
            ins_cnt_reg    <= '0;
            fix_cnt_reg    <= '0;
            tot_excl_reg   <= '0;
            tot_lowq_reg   <= '0;
            tot_unal_reg   <= '0;
            tot_del_reg    <= '0;
            tot_ins_reg    <= '0;
            tot_fix_reg    <= '0;
        end
        else if (pop)
        begin
            held_op_reg    <= held_op_next;
            held_valid_reg <= held_valid_next;
            prior_op_reg   <= prior_op_next;
            match_seen_reg <= match_seen_next;
            del_cnt_reg    <= tok.last ? '0 : del_cnt_next;
            ins_cnt_reg    <= tok.last ? '0 : ins_cnt_next;
            fix_cnt_reg    <= tok.last ? '0 : fix_cnt_next;
            tot_excl_reg   <= tot_excl_next;
            tot_lowq_reg   <= tot_lowq_next;
            tot_unal_reg   <= tot_unal_next;
            tot_del_reg    <= tot_del_next;
            tot_ins_reg    <= tot_ins_next;
            tot_fix_reg    <= tot_fix_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop && tok.last)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop && tok.last)
            out_data_reg <= out_data_next;
    end

endmodule

>>> rtl/core/arfcc_checker.sv
module arfcc_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input arfcc_pkg::out_beat_t out_data
);
    import arfcc_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    a_pass_reason: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.read_pass == (out_data.fail_reason == VERDICT_PASS))
        else $error("read_pass disagrees with fail_reason");

    a_fail_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.read_pass |->
            out_data.bad_deletions == '0 && out_data.bad_insertions == '0 &&
            out_data.fixable_insertions == '0 && !out_data.no_match)
        else $error("failed read reports op counts");

    a_nomatch_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.no_match |-> out_data.total_unaligned != '0)
        else $error("unaligned read not reflected in total");

endmodule

bind aligned_read_filter_cigar_check_core arfcc_checker u_arfcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

>>> tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import arfcc_pkg::*;

    localparam logic [OP_W-1:0] OP_N  = 4'd3;
    localparam logic [OP_W-1:0] OP_P  = 4'd6;
    localparam logic [OP_W-1:0] OP_EQ = 4'd7;
    localparam logic [OP_W-1:0] OP_X  = 4'd8;
    localparam int IDLE_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 6;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_beat_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_beat_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    aligned_read_filter_cigar_check_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // screening state
    logic [8:0]      qual_cutoff = '0;
    logic [15:0]     excl_mask = '0;
    logic [OP_W-1:0] held_op = '0;
    logic            held_valid = 1'b0;
    logic [OP_W-1:0] prior_op = OP_START;
    verdict_e        verdict = VERDICT_PASS;
    logic [CNT_W-1:0] read_cnt [3] = '{default: '0};
    logic            match_seen = 1'b0;
    logic [TOT_W-1:0] run_tot [6] = '{default: '0};

    in_beat_t  read_beats [$];
    out_beat_t read_reports [$];

    int queued = 0;
    int fault_count = 0;
    int idle_cycles = 0;
    int in_gap = 0;
    int stall_left = 0;
    bit idling = 1'b1;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [OP_W-1:0] rand_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return OP_M;
        if (r < 58)
            return OP_I;
        if (r < 72)
            return OP_D;
        if (r < 82)
            return OP_S;
        if (r < 95)
            return 4'($urandom_range(OP_N, OP_X));
        return 4'($urandom_range(OP_OTHER, OP_START));
    endfunction

    task automatic clear_read();
        held_op = '0;
        held_valid = 1'b0;
        prior_op = OP_START;
        read_cnt = '{default: '0};
        match_seen = 1'b0;
    endtask

    task automatic bump(input int k);
        if (read_cnt[k] != {CNT_W{1'b1}})
            read_cnt[k]++;
        run_tot[3 + k]++;
    endtask

    task automatic grade_op(input logic [OP_W-1:0] op, input logic has_next,
                            input logic [OP_W-1:0] nxt, input logic next_last);
        logic framed;
        framed = has_next && nxt == OP_M;
        if (op == OP_M)
            match_seen = 1'b1;
        else if (op == OP_D)
        begin
            if (prior_op != OP_M || !framed)
                bump(0);
        end
        else if (op == OP_I && (prior_op != OP_M || !framed))
        begin
            if (prior_op != OP_M)
                bump((prior_op != OP_START && prior_op != OP_S) ? 1 : 2);
            else if (!has_next || (next_last && nxt == OP_S))
                bump(2);
            else
                bump(1);
        end
        prior_op = op;
    endtask

    task automatic screen_beat(input in_beat_t b);
        logic [OP_W-1:0] code;
        logic nm;
        out_beat_t r;
        code = (b.op_code > OP_LAST) ? OP_OTHER : b.op_code;
        if (b.first_item)
        begin
            clear_read();
            if ((b.read_flag & excl_mask) != '0)
            begin
                verdict = VERDICT_EXCLUDED;
                run_tot[0]++;
            end
            else if (b.map_quality < qual_cutoff)
            begin
                verdict = VERDICT_LOW_QUAL;
                run_tot[1]++;
            end
            else
                verdict = VERDICT_PASS;
        end
        if (verdict == VERDICT_PASS && b.has_op)
        begin
            if (held_valid)
                grade_op(held_op, 1'b1, code, b.last_item);
            held_op = code;
            held_valid = 1'b1;
        end
        if (b.last_item)
        begin
            if (verdict == VERDICT_PASS && held_valid)
            begin
                grade_op(held_op, 1'b0, OP_M, 1'b0);
                held_valid = 1'b0;
            end
            nm = verdict == VERDICT_PASS && prior_op != OP_START && !match_seen;
            if (nm)
                run_tot[2]++;
            r.read_pass = verdict == VERDICT_PASS;
            r.fail_reason = verdict;
            r.bad_deletions = read_cnt[0];
            r.bad_insertions = read_cnt[1];
            r.fixable_insertions = read_cnt[2];
            r.no_match = nm;
            r.total_excluded = run_tot[0];
            r.total_low_quality = run_tot[1];
            r.total_unaligned = run_tot[2];
            r.total_bad_deletions = run_tot[3];
            r.total_bad_insertions = run_tot[4];
            r.total_fixable_insertions = run_tot[5];
            read_reports.push_back(r);
            clear_read();
        end
    endtask

    task automatic field_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
        fault_count++;
        if (fault_count <= 10)
            $display("mismatch %s: expected %0h, got %0h", field, want, got);
    endtask

    task automatic check_report(input out_beat_t got);
        out_beat_t want;
        if (read_reports.size() == 0)
        begin
            fault_count++;
            if (fault_count <= 10)
                $display("unexpected read report: %h", got);
            return;
        end
        want = read_reports.pop_front();
        if (got.read_pass !== want.read_pass)
            field_mismatch("read_pass", want.read_pass, got.read_pass);
        if (got.fail_reason !== want.fail_reason)
            field_mismatch("fail_reason", want.fail_reason, got.fail_reason);
        if (got.bad_deletions !== want.bad_deletions)
            field_mismatch("bad_deletions", want.bad_deletions, got.bad_deletions);
        if (got.bad_insertions !== want.bad_insertions)
            field_mismatch("bad_insertions", want.bad_insertions, got.bad_insertions);
        if (got.fixable_insertions !== want.fixable_insertions)
            field_mismatch("fixable_insertions", want.fixable_insertions,
                           got.fixable_insertions);
        if (got.no_match !== want.no_match)
            field_mismatch("no_match", want.no_match, got.no_match);
        if (got.total_excluded !== want.total_excluded)
            field_mismatch("total_excluded", want.total_excluded, got.total_excluded);
        if (got.total_low_quality !== want.total_low_quality)
            field_mismatch("total_low_quality", want.total_low_quality,
                           got.total_low_quality);
        if (got.total_unaligned !== want.total_unaligned)
            field_mismatch("total_unaligned", want.total_unaligned, got.total_unaligned);
        if (got.total_bad_deletions !== want.total_bad_deletions)
            field_mismatch("total_bad_deletions", want.total_bad_deletions,
                           got.total_bad_deletions);
        if (got.total_bad_insertions !== want.total_bad_insertions)
            field_mismatch("total_bad_insertions", want.total_bad_insertions,
                           got.total_bad_insertions);
        if (got.total_fixable_insertions !== want.total_fixable_insertions)
            field_mismatch("total_fixable_insertions", want.total_fixable_insertions,
                           got.total_fixable_insertions);
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap--;
            end
            else if (read_beats.size() > 0)
            begin
                in_data <= read_beats.pop_front();
                in_valid <= 1'b1;
                in_gap = idling ? pick_gap() : 0;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_left = idling ? pick_gap() : 0;
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_report(out_data);
            if (in_valid && in_ready)
                screen_beat(in_data);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("testbench: done, errors");
                    $finish;
                end
            end
        end
    end

    task automatic beat(input logic [15:0] flag, input logic [7:0] q, input logic has_op,
                        input logic [OP_W-1:0] op, input logic is_first, input logic is_last);
        in_beat_t b;
        b.read_flag = flag;
        b.map_quality = q;
        b.has_op = has_op;
        b.op_code = op;
        b.first_item = is_first;
        b.last_item = is_last;
        read_beats.push_back(b);
        queued++;
    endtask

    task automatic queue_read(input logic [15:0] flag, input logic [7:0] q, input int nops);
        int k;
        logic [15:0] f;
        logic [7:0] mq;
        if (nops == 0)
        begin
            beat(flag, q, 1'b0, 4'($urandom), 1'b1, 1'b1);
            return;
        end
        for (k = 0; k < nops; k++)
        begin
            f = (k == 0) ? flag : 16'($urandom);
            mq = (k == 0) ? q : 8'($urandom);
            if (k == nops - 1 && $urandom_range(0, 9) == 0)
            begin
                // closing beat without an operation
                beat(f, mq, 1'b1, rand_op(), k == 0, 1'b0);
                beat(16'($urandom), 8'($urandom), 1'b0, 4'($urandom), 1'b0, 1'b1);
            end
            else
                beat(f, mq, 1'b1, rand_op(), k == 0, k == nops - 1);
        end
    endtask

    task automatic random_reads(input int n);
        int target;
        int r;
        int nops;
        logic [15:0] f;
        logic [7:0] q;
        target = queued + n;
        while (queued < target)
        begin
            r = $urandom_range(0, 99);
            f = 16'($urandom);
            q = 8'($urandom);
            if ($urandom_range(0, 2) != 0)
            begin
                f = f & ~excl_mask;
                if (qual_cutoff <= 9'd255)
                    q = 8'($urandom_range(qual_cutoff, 255));
            end
            nops = $urandom_range(0, 19);
            nops = (nops == 0) ? 0 : (nops < 17) ? $urandom_range(1, 6) : $urandom_range(7, 40);
            if (r < 85)
                queue_read(f, q, nops);
            else
                beat(16'($urandom), 8'($urandom), 1'($urandom), 4'($urandom),
                     1'($urandom), 1'($urandom));
        end
    endtask

    task automatic cfg_write(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        if (idx == CFG_QUALITY_CUTOFF)
            qual_cutoff = val[8:0];
        else
            excl_mask = val;
    endtask

    task automatic settle();
        @(negedge clk);
        while (read_beats.size() != 0 || in_valid || read_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        cfg_write(CFG_QUALITY_CUTOFF, 16'd20);
        cfg_write(CFG_EXCLUDE_MASK, 16'h0404);
        beat(16'h0000, 8'd255, 1'b0, OP_M, 1'b1, 1'b1);
        beat(16'hFFFF, 8'd255, 1'b1, OP_M, 1'b1, 1'b0);
        beat(16'h0000, 8'd0, 1'b1, OP_D, 1'b0, 1'b1);
        beat(16'hFBFB, 8'd20, 1'b1, OP_M, 1'b1, 1'b0);
        beat(16'h0000, 8'd0, 1'b1, OP_D, 1'b0, 1'b0);
        beat(16'h0000, 8'd0, 1'b1, OP_M, 1'b0, 1'b0);
        beat(16'h0000, 8'd0, 1'b1, OP_I, 1'b0, 1'b0);
        beat(16'h0000, 8'd0, 1'b1, OP_S, 1'b0, 1'b1);
        beat(16'h0001, 8'd200, 1'b1, OP_I, 1'b1, 1'b0);
        beat(16'h0000, 8'd0, 1'b1, OP_M, 1'b0, 1'b0);
        beat(16'h0000, 8'd0, 1'b1, OP_D, 1'b0, 1'b1);
        beat(16'h0002, 8'd100, 1'b1, OP_S, 1'b1, 1'b0);
        beat(16'h0000, 8'd0, 1'b1, OP_I, 1'b0, 1'b0);
        beat(16'h0000, 8'd0, 1'b1, OP_M, 1'b0, 1'b0);
        beat(16'h0000, 8'd0, 1'b1, OP_I, 1'b0, 1'b1);
        beat(16'h8000, 8'd255, 1'b1, OP_D, 1'b1, 1'b0);
        beat(16'h0000, 8'd0, 1'b1, OP_I, 1'b0, 1'b0);
        beat(16'h0000, 8'd0, 1'b1, OP_OTHER, 1'b0, 1'b0);
        beat(16'h0000, 8'd0, 1'b1, OP_START, 1'b0, 1'b1);
        // new read opens while the previous one is still open
        beat(16'h0000, 8'd255, 1'b1, OP_M, 1'b1, 1'b0);
        beat(16'h0000, 8'd255, 1'b1, OP_X, 1'b1, 1'b1);
        // beats after a finished read, no first mark
        beat(16'h0000, 8'd0, 1'b1, OP_M, 1'b0, 1'b0);
        beat(16'h0000, 8'd0, 1'b0, OP_P, 1'b0, 1'b1);
        beat(16'h0000, 8'd19, 1'b1, OP_M, 1'b1, 1'b1);
        beat(16'h0000, 8'd255, 1'b1, OP_EQ, 1'b0, 1'b1);
        settle();

        cfg_write(CFG_QUALITY_CUTOFF, 16'd0);
        cfg_write(CFG_EXCLUDE_MASK, 16'h0000);
        random_reads(200);
        settle();

        idling = 1'b0;
        cfg_write(CFG_QUALITY_CUTOFF, 16'd256);
        cfg_write(CFG_EXCLUDE_MASK, 16'hFFFF);
        random_reads(100);
        settle();
        idling = 1'b1;

        cfg_write(CFG_QUALITY_CUTOFF, 16'($urandom_range(1, 255)));
        cfg_write(CFG_EXCLUDE_MASK, 16'(1 << $urandom_range(0, 15)));
        random_reads(320);
        settle();

        cfg_write(CFG_QUALITY_CUTOFF, 16'd255);
        cfg_write(CFG_EXCLUDE_MASK, 16'h8000);
        // long read of deletions: per-read count saturates
        beat(16'h0000, 8'd255, 1'b1, OP_D, 1'b1, 1'b0);
        repeat (528) beat(16'($urandom), 8'($urandom), 1'b1, OP_D, 1'b0, 1'b0);
        beat(16'h0000, 8'd0, 1'b1, OP_D, 1'b0, 1'b1);
        random_reads(100);
        settle();

        if (fault_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
